### hdl/tbtod_pkg.sv
// ----------------------------------------------------------------------------
// tbtod_pkg
// Shared types, constants and small decode helpers of the time-of-day unit.
// ----------------------------------------------------------------------------
`default_nettype none
package tbtod_pkg;

  localparam int CountWidthDefault = 64;
  localparam int RegWidth          = 64;
  localparam int IndexWidth        = 3;

  typedef enum logic [IndexWidth-1:0] {
    REG_TICK_RATE    = 3'd0,
    REG_BASE_COUNT   = 3'd1,
    REG_BASE_HOUR    = 3'd2,
    REG_BASE_MINUTE  = 3'd3,
    REG_BASE_SECOND  = 3'd4,
    REG_CLOCK_FORMAT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic valid;
    logic raw;
  } ctl_t;

  // low nibble plus ten times high nibble, nibbles above nine kept as they are
  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    logic [7:0] hi;
    hi = {4'd0, v[7:4]};
    return {4'd0, v[3:0]} + (hi << 3) + (hi << 1);
  endfunction

  // remainder by twelve for values below 192
  function automatic logic [7:0] mod12(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd96) r = r - 8'd96;
    if (r >= 8'd48) r = r - 8'd48;
    if (r >= 8'd24) r = r - 8'd24;
    if (r >= 8'd12) r = r - 8'd12;
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/tbtod_cell.sv
// ----------------------------------------------------------------------------
// tbtod_cell
// One restoring division step; the quotient bit is folded into a running
// hour/minute/second count kept modulo one day; a raw entry passes its time through.
// ----------------------------------------------------------------------------
`default_nettype none
module tbtod_cell #(
  parameter int W = tbtod_pkg::CountWidthDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [63:0]           divisor,
  input  wire tbtod_pkg::ctl_t       in_ctl,
  input  wire logic [W-1:0]          in_rem,
  input  wire logic [W-1:0]          in_dvd,
  input  wire tbtod_pkg::tod_t       in_tod,
  output tbtod_pkg::ctl_t            out_ctl,
  output logic [W-1:0]               out_rem,
  output logic [W-1:0]               out_dvd,
  output tbtod_pkg::tod_t            out_tod
);
  import tbtod_pkg::*;

  logic [W:0]   trial;
  logic [64:0]  trial_x;
  logic [64:0]  diff;
  logic         qbit;
  logic [W-1:0] rem_next;
  logic [6:0]   s2;
  logic [6:0]   m2;
  logic [5:0]   h2;
  logic         cs;
  logic         cm;
  tod_t         tod_next;

  always_comb begin
    trial    = {in_rem, in_dvd[W-1]};
    trial_x  = 65'(trial);
    diff     = trial_x - {1'b0, divisor};
    qbit     = trial_x >= {1'b0, divisor};
    rem_next = qbit ? diff[W-1:0] : trial[W-1:0];
    // double the running count and add the new quotient bit
    s2 = {in_tod.second, 1'b0} + 7'(qbit);
    cs = s2 >= 7'd60;
    if (cs) s2 = s2 - 7'd60;
    m2 = {in_tod.minute, 1'b0} + 7'(cs);
    cm = m2 >= 7'd60;
    if (cm) m2 = m2 - 7'd60;
    h2 = {in_tod.hour, 1'b0} + 6'(cm);
    if (h2 >= 6'd24) h2 = h2 - 6'd24;
    if (in_ctl.raw) begin
      tod_next = in_tod;
    end else begin
      tod_next = '{hour: h2[4:0], minute: m2[5:0], second: s2[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
    out_rem <= rem_next;
    out_dvd <= {in_dvd[W-2:0], 1'b0};
    out_tod <= tod_next;
  end

endmodule
`default_nettype wire

### hdl/tick_based_time_of_day_unit.sv
// ----------------------------------------------------------------------------
// tick_based_time_of_day_unit
// Time of day from a tick counter and a base snapshot, or from raw RTC regs.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  query    | start, busy               | counter_now, raw_second/minute/hour
//  result   | done (one-cycle strobe)   | hour, minute, second
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
//  a query is taken every cycle; busy stays low and cfg_ready stays high
//  pipeline stages: input register, a division cell for each counter bit,
//  then the base-time add
//  rst clears the config registers and the valid bits of every stage
//  results cannot be stalled; done marks each one for a single cycle
`default_nettype none
module tick_based_time_of_day_unit #(
  parameter int COUNT_WIDTH = tbtod_pkg::CountWidthDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [63:0]                     counter_now,
  input  wire logic [7:0]                      raw_second,
  input  wire logic [7:0]                      raw_minute,
  input  wire logic [7:0]                      raw_hour,
  output logic                                 done,
  output logic [4:0]                           hour,
  output logic [5:0]                           minute,
  output logic [5:0]                           second,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tbtod_pkg::IndexWidth-1:0] cfg_index,
  input  wire logic [tbtod_pkg::RegWidth-1:0]   cfg_data
);
  import tbtod_pkg::*;

  localparam int W = COUNT_WIDTH;

  logic [63:0] tick_rate;
  logic [63:0] base_count;
  logic [4:0]  base_hour;
  logic [5:0]  base_minute;
  logic [5:0]  base_second;
  logic [1:0]  clock_format;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate    <= '0;
      base_count   <= '0;
      base_hour    <= '0;
      base_minute  <= '0;
      base_second  <= '0;
      clock_format <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TICK_RATE:    tick_rate    <= cfg_data;
        REG_BASE_COUNT:   base_count   <= cfg_data;
        REG_BASE_HOUR:    base_hour    <= cfg_data[4:0];
        REG_BASE_MINUTE:  base_minute  <= cfg_data[5:0];
        REG_BASE_SECOND:  base_second  <= cfg_data[5:0];
        REG_CLOCK_FORMAT: clock_format <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // raw register decode
  logic [7:0] rs;
  logic [7:0] rm;
  logic [7:0] rh;
  tod_t       raw_tod;

  always_comb begin
    rs = raw_second;
    rm = raw_minute;
    rh = clock_format[1] ? raw_hour : {1'b0, raw_hour[6:0]};
    if (!clock_format[0]) begin
      rs = from_bcd(rs);
      rm = from_bcd(rm);
      rh = from_bcd(rh);
    end
    if (!clock_format[1]) begin
      rh = mod12(rh) + (raw_hour[7] ? 8'd12 : 8'd0);
    end
    raw_tod = '{hour: rh[4:0], minute: rm[5:0], second: rs[5:0]};
  end

  // input register
  ctl_t         ctl   [0:W];
  logic [W-1:0] rem   [0:W];
  logic [W-1:0] dvd   [0:W];
  tod_t         tod   [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else begin
      ctl[0] <= '{valid: start && !busy, raw: tick_rate == 64'd0};
    end
    rem[0] <= '0;
    dvd[0] <= counter_now[W-1:0] - base_count[W-1:0];
    tod[0] <= (tick_rate == 64'd0) ? raw_tod : tod_t'('0);
  end

  for (genvar i = 0; i < W; i++) begin : g_cell
    tbtod_cell #(.W(W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .divisor (tick_rate),
      .in_ctl  (ctl[i]),
      .in_rem  (rem[i]),
      .in_dvd  (dvd[i]),
      .in_tod  (tod[i]),
      .out_ctl (ctl[i+1]),
      .out_rem (rem[i+1]),
      .out_dvd (dvd[i+1]),
      .out_tod (tod[i+1])
    );
  end

  // base-time add with carries
  logic [6:0] ts;
  logic [6:0] tm;
  logic [5:0] th;
  logic [1:0] c_s;
  logic [1:0] c_m;
  tod_t       sum_tod;
  logic       out_raw;

  always_comb begin
    ts = 7'(base_second) + 7'(tod[W].second);
    priority if (ts >= 7'd120) begin
      ts = ts - 7'd120; c_s = 2'd2;
    end else if (ts >= 7'd60) begin
      ts = ts - 7'd60;  c_s = 2'd1;
    end else begin
      c_s = 2'd0;
    end
    tm = 7'(base_minute) + 7'(tod[W].minute) + 7'(c_s);
    priority if (tm >= 7'd120) begin
      tm = tm - 7'd120; c_m = 2'd2;
    end else if (tm >= 7'd60) begin
      tm = tm - 7'd60;  c_m = 2'd1;
    end else begin
      c_m = 2'd0;
    end
    th = 6'(base_hour) + 6'(tod[W].hour) + 6'(c_m);
    if (th >= 6'd48) th = th - 6'd48;
    if (th >= 6'd24) th = th - 6'd24;
    sum_tod = '{hour: th[4:0], minute: tm[5:0], second: ts[5:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[W].valid;
    end
    out_raw <= ctl[W].raw;
    if (ctl[W].raw) begin
      {hour, minute, second} <= tod[W];
    end else begin
      {hour, minute, second} <= sum_tod;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(W+2) done)
    else $error("accepted query gave no result");

  a_range: assert property (@(posedge clk) disable iff (rst)
    (done && !out_raw) |-> (hour < 5'd24 && minute < 6'd60 && second < 6'd60))
    else $error("tick-mode time out of range");

  a_rem: assert property (@(posedge clk) disable iff (rst)
    (ctl[W].valid && !ctl[W].raw) |-> (64'(rem[W]) < tick_rate))
    else $error("division remainder not below tick rate");

endmodule
`default_nettype wire
